// ----- sv/lura_pkg.sv -----
// Shared types, codes and widths for the least-used resource allocator.
`timescale 1ns / 1ps

package lura_pkg;

    // Field widths fixed by the request and result formats.
    localparam int MODE_W = 2;
    localparam int IDX_W  = 3;
    localparam int TIME_W = 32;
    localparam int CNT_W  = 32;
    localparam int STAT_W = 2;

    // Default pool size.
    localparam int DEF_NUM_SLOTS = 8;

    // Request modes.
    localparam logic [MODE_W-1:0] MODE_ACQUIRE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BREAK   = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_NONE  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic acq_rd;
        logic acq_commit;
        logic rel_commit;
        logic brk_step;
        logic set_range;
        logic push;
    } lura_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_acq;
        logic is_rel;
        logic is_brk;
        logic idx_ok;
        logic step_last;
        logic brk_hit;
        logic out_free;
    } lura_sts_t;

endpackage

// ----- sv/lura_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module lura_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/lura_ctrl.sv -----
// Controller state machine that sequences acquire, release and break requests.
`timescale 1ns / 1ps

module lura_ctrl
    import lura_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  lura_sts_t sts,
    output lura_cmd_t cmd
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_DECODE   = 8'b0000_0010,
        S_ACQ_SCAN = 8'b0000_0100,
        S_ACQ_FIN  = 8'b0000_1000,
        S_ACQ_WR   = 8'b0001_0000,
        S_REL_WR   = 8'b0010_0000,
        S_BRK_SCAN = 8'b0100_0000,
        S_RESULT   = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                priority if (sts.is_acq)
                begin
                    state_next = S_ACQ_SCAN;
                end
                else if (sts.is_rel && sts.idx_ok)
                begin
                    state_next = S_REL_WR;
                end
                else if (sts.is_brk && sts.idx_ok)
                begin
                    state_next = S_BRK_SCAN;
                end
                else
                begin
                    cmd.set_range = 1'b1;
                    state_next    = S_RESULT;
                end
            end
            S_ACQ_SCAN:
            begin
                cmd.acq_rd = 1'b1;
                if (sts.step_last)
                begin
                    state_next = S_ACQ_FIN;
                end
            end
            S_ACQ_FIN:
            begin
                state_next = S_ACQ_WR;
            end
            S_ACQ_WR:
            begin
                cmd.acq_commit = 1'b1;
                state_next     = S_RESULT;
            end
            S_REL_WR:
            begin
                cmd.rel_commit = 1'b1;
                state_next     = S_RESULT;
            end
            S_BRK_SCAN:
            begin
                cmd.brk_step = 1'b1;
                if (sts.brk_hit || sts.step_last)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/lura_dp.sv -----
// Datapath: slot flags, use-count and busy-time memories, scan logic and result register.
`timescale 1ns / 1ps

module lura_dp
    import lura_pkg::*;
#(
    parameter int NUM_SLOTS = DEF_NUM_SLOTS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [MODE_W-1:0] mode,
    input  logic [IDX_W-1:0]  slot_index,
    input  logic [TIME_W-1:0] use_duration,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [STAT_W-1:0] status,
    output logic [IDX_W-1:0]  granted_index,
    input  lura_cmd_t         cmd,
    output lura_sts_t         sts
);

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

    // Captured request.
    logic [MODE_W-1:0] mode_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [TIME_W-1:0] time_reg;

    // Scan pointer and step count.
    logic [SLOT_W-1:0] scan_reg;
    logic [SLOT_W-1:0] step_reg;

    // Per-slot state held in flip-flops.
    logic [NUM_SLOTS-1:0] busy_reg;
    logic [NUM_SLOTS-1:0] broken_reg;
    logic [NUM_SLOTS-1:0] use_vld_reg;
    logic [NUM_SLOTS-1:0] time_vld_reg;

    // Compare stage of the acquire scan.
    logic              cmp_pend_reg;
    logic [SLOT_W-1:0] cmp_idx_reg;
    logic              cmp_vld_reg;
    logic              found_reg;
    logic [SLOT_W-1:0] best_idx_reg;
    logic [CNT_W-1:0]  best_cnt_reg;

    // Result waiting for the output register, and the output register itself.
    logic [STAT_W-1:0] res_status_reg;
    logic [IDX_W-1:0]  res_index_reg;
    logic              out_valid_reg;
    logic [STAT_W-1:0] out_status_reg;
    logic [IDX_W-1:0]  out_index_reg;

    logic [SLOT_W-1:0] idx_slot;
    logic [SLOT_W-1:0] in_slot;
    logic [SLOT_W-1:0] scan_next;
    logic [NUM_SLOTS-1:0] elig;
    logic [CNT_W-1:0]  use_rdata;
    logic [CNT_W-1:0]  cmp_cnt;
    logic              cmp_take;
    logic [CNT_W-1:0]  cnt_inc;
    logic [TIME_W-1:0] time_rdata;
    logic [TIME_W-1:0] time_old;
    logic [TIME_W-1:0] time_sum;
    logic              idx_ok;
    logic              brk_hit;
    logic              step_last;
    logic              out_free;

    assign idx_slot  = SLOT_W'(idx_reg);
    assign in_slot   = SLOT_W'(slot_index);
    assign scan_next = (scan_reg == LAST_SLOT) ? '0 : scan_reg + 1'b1;
    assign elig      = ~busy_reg & ~broken_reg;
    assign idx_ok    = ({{(32 - IDX_W){1'b0}}, idx_reg} < 32'(NUM_SLOTS));
    assign step_last = (step_reg == LAST_SLOT);
    assign brk_hit   = elig[scan_reg];

    // A slot never written reads as a zero count.
    assign cmp_cnt  = cmp_vld_reg ? use_rdata : '0;
    assign cmp_take = cmp_pend_reg && elig[cmp_idx_reg]
                      && (!found_reg || (cmp_cnt < best_cnt_reg));
    assign cnt_inc  = (best_cnt_reg == {CNT_W{1'b1}}) ? best_cnt_reg
                                                       : best_cnt_reg + 1'b1;

    assign time_old = time_vld_reg[idx_slot] ? time_rdata : '0;
    assign time_sum = time_old + time_reg;

    assign out_free = !out_valid_reg || out_ready;

    lura_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NUM_SLOTS)
    ) u_use_ram (
        .clk   (clk),
        .we    (cmd.acq_commit && found_reg),
        .waddr (best_idx_reg),
        .wdata (cnt_inc),
        .raddr (scan_reg),
        .rdata (use_rdata)
    );

    lura_ram #(
        .WIDTH (TIME_W),
        .DEPTH (NUM_SLOTS)
    ) u_time_ram (
        .clk   (clk),
        .we    (cmd.rel_commit),
        .waddr (idx_slot),
        .wdata (time_sum),
        .raddr (idx_slot),
        .rdata (time_rdata)
    );

    // Request capture and scan bookkeeping.
    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= scan_reg;
        cmp_vld_reg <= use_vld_reg[scan_reg];
        if (cmd.load)
        begin
            mode_reg <= mode;
            idx_reg  <= slot_index;
            time_reg <= use_duration;
            step_reg <= '0;
            if (mode == MODE_BREAK)
            begin
                scan_reg <= in_slot;
            end
            else
            begin
                scan_reg <= '0;
            end
        end
        else if (cmd.acq_rd || (cmd.brk_step && !brk_hit))
        begin
            scan_reg <= scan_next;
            step_reg <= step_reg + 1'b1;
        end
        if (cmp_take)
        begin
            best_idx_reg <= cmp_idx_reg;
            best_cnt_reg <= cmp_cnt;
        end
    end

    // Control state of the datapath.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= '0;
            broken_reg     <= '0;
            use_vld_reg    <= '0;
            time_vld_reg   <= '0;
            cmp_pend_reg   <= 1'b0;
            found_reg      <= 1'b0;
            res_status_reg <= ST_DONE;
            res_index_reg  <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_DONE;
            out_index_reg  <= '0;
        end
        else
        begin
            cmp_pend_reg <= cmd.acq_rd;
            if (cmd.load)
            begin
                found_reg <= 1'b0;
            end
            else if (cmp_take)
            begin
                found_reg <= 1'b1;
            end

            if (cmd.set_range)
            begin
                res_status_reg <= ST_RANGE;
                res_index_reg  <= '0;
            end

            if (cmd.acq_commit)
            begin
                if (found_reg)
                begin
                    busy_reg[best_idx_reg]    <= 1'b1;
                    use_vld_reg[best_idx_reg] <= 1'b1;
                    res_status_reg            <= ST_DONE;
                    res_index_reg             <= IDX_W'(best_idx_reg);
                end
                else
                begin
                    res_status_reg <= ST_NONE;
                    res_index_reg  <= '0;
                end
            end

            if (cmd.rel_commit)
            begin
                busy_reg[idx_slot]     <= 1'b0;
                time_vld_reg[idx_slot] <= 1'b1;
                res_status_reg         <= ST_DONE;
                res_index_reg          <= '0;
            end

            if (cmd.brk_step)
            begin
                if (brk_hit)
                begin
                    broken_reg[scan_reg] <= 1'b1;
                    res_status_reg       <= ST_DONE;
                    res_index_reg        <= IDX_W'(scan_reg);
                end
                else if (step_last)
                begin
                    res_status_reg <= ST_NONE;
                    res_index_reg  <= '0;
                end
            end

            if (cmd.push)
            begin
                out_valid_reg  <= 1'b1;
                out_status_reg <= res_status_reg;
                out_index_reg  <= res_index_reg;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.is_acq    = (mode_reg == MODE_ACQUIRE);
    assign sts.is_rel    = (mode_reg == MODE_RELEASE);
    assign sts.is_brk    = (mode_reg == MODE_BREAK);
    assign sts.idx_ok    = idx_ok;
    assign sts.step_last = step_last;
    assign sts.brk_hit   = brk_hit;
    assign sts.out_free  = out_free;

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign granted_index = out_index_reg;

endmodule

// ----- sv/least_used_resource_allocator_unit.sv -----
// Top level of the least-used resource allocator: controller and datapath.
`timescale 1ns / 1ps

// The allocator keeps a pool of NUM_SLOTS resource slots, each with a busy
// flag, a broken flag, a saturating 32-bit use count and a wrapping 32-bit
// busy-time total, all cleared by reset. Each request yields exactly one
// result. An acquire request grants the free, healthy slot with the lowest
// use count (lowest index on ties), marks it busy and counts the use; a
// release request clears the busy flag of slot_index and adds use_duration to
// its total; a break request walks the pool from slot_index, wrapping round,
// and marks the first free healthy slot broken. The block handles one
// request at a time. An acquire passes through decode, a scan that reads
// one use count a cycle from the use-count memory, then a compare, a
// write-back and a result state; a break scans one slot per cycle from
// decode until a free healthy slot is found or the pool has been walked;
// a release passes through decode, a write and a result state, and an
// out-of-range request goes from decode straight to the result state. A
// new request is accepted in the cycle after the previous result has been
// moved into the output register, even while that result still waits there
// for out_ready; a result that cannot enter the output register holds the
// controller, and the input with it, until out_ready frees the register.

module least_used_resource_allocator_unit
    import lura_pkg::*;
#(
    parameter int NUM_SLOTS = DEF_NUM_SLOTS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [MODE_W-1:0] mode,
    input  logic [IDX_W-1:0]  slot_index,
    input  logic [TIME_W-1:0] use_duration,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [STAT_W-1:0] status,
    output logic [IDX_W-1:0]  granted_index
);

    lura_cmd_t cmd;
    lura_sts_t sts;

    // The controller steps through each request and issues commands.
    lura_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the slot state, performs the scans and owns the
    // output register.
    lura_dp #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .mode          (mode),
        .slot_index    (slot_index),
        .use_duration  (use_duration),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .granted_index (granted_index),
        .cmd           (cmd),
        .sts           (sts)
    );

endmodule
